@@ hw/rtl/psbf_pkg.sv @@
package psbf_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 256;
  localparam int MAX_HEIGHT_DEFAULT = 256;

  localparam int CH_W     = 13;
  localparam int PIX_W    = 4 * CH_W;
  localparam int ONE_Q12  = 4096;
  localparam int FLASH_MIN = 41;
  localparam int THREE_TENTHS_Q12 = 1229;

  localparam logic [8:0]  FRAME_WIDTH_RST  = 9'd256;
  localparam logic [8:0]  FRAME_HEIGHT_RST = 9'd256;
  localparam logic [15:0] GAIN_RST         = 16'd4096;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SHAKE_DX     = 3'd2,
    REG_SHAKE_DY     = 3'd3,
    REG_GAIN         = 3'd4,
    REG_WARM_SHIFT   = 3'd5,
    REG_FLASH_LEVEL  = 3'd6
  } reg_index_t;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_PROCESS = 1'b1
  } func_t;

  typedef struct packed {
    logic        [8:0]  frame_width;
    logic        [8:0]  frame_height;
    logic signed [8:0]  shake_dx;
    logic signed [8:0]  shake_dy;
    logic        [15:0] brightness_gain;
    logic        [15:0] warm_shift;
    logic        [13:0] flash_level;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic load_wr;
    logic addr_en;
    logic rd_en;
    logic mul_en;
    logic mix_en;
    logic fin_en;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/psbf_regs.sv @@
module psbf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psbf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output psbf_pkg::cfg_t                 cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= psbf_pkg::FRAME_WIDTH_RST;
      cfg.frame_height    <= psbf_pkg::FRAME_HEIGHT_RST;
      cfg.shake_dx        <= '0;
      cfg.shake_dy        <= '0;
      cfg.brightness_gain <= psbf_pkg::GAIN_RST;
      cfg.warm_shift      <= '0;
      cfg.flash_level     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        psbf_pkg::REG_FRAME_WIDTH:  cfg.frame_width     <= pwdata[8:0];
        psbf_pkg::REG_FRAME_HEIGHT: cfg.frame_height    <= pwdata[8:0];
        psbf_pkg::REG_SHAKE_DX:     cfg.shake_dx        <= $signed(pwdata[8:0]);
        psbf_pkg::REG_SHAKE_DY:     cfg.shake_dy        <= $signed(pwdata[8:0]);
        psbf_pkg::REG_GAIN:         cfg.brightness_gain <= pwdata[15:0];
        psbf_pkg::REG_WARM_SHIFT:   cfg.warm_shift      <= pwdata[15:0];
        psbf_pkg::REG_FLASH_LEVEL:  cfg.flash_level     <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psbf_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg.frame_width);
      psbf_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      psbf_pkg::REG_SHAKE_DX:     prdata = 32'(unsigned'(cfg.shake_dx));
      psbf_pkg::REG_SHAKE_DY:     prdata = 32'(unsigned'(cfg.shake_dy));
      psbf_pkg::REG_GAIN:         prdata = 32'(cfg.brightness_gain);
      psbf_pkg::REG_WARM_SHIFT:   prdata = 32'(cfg.warm_shift);
      psbf_pkg::REG_FLASH_LEVEL:  prdata = 32'(cfg.flash_level);
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/psbf_ctrl.sv @@
module psbf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  func,
  output logic                  busy,
  output psbf_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ADDR,
    S_READ,
    S_SCALE,
    S_MIX,
    S_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (func == psbf_pkg::FUNC_LOAD) ? S_LOAD : S_ADDR;
          end
        end
        S_LOAD:   state <= S_IDLE;
        S_ADDR:   state <= S_READ;
        S_READ:   state <= S_SCALE;
        S_SCALE:  state <= S_MIX;
        S_MIX:    state <= S_FINISH;
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.latch   = accept;
    cmd.load_wr = (state == S_LOAD);
    cmd.addr_en = (state == S_ADDR);
    cmd.rd_en   = (state == S_READ);
    cmd.mul_en  = (state == S_SCALE);
    cmd.mix_en  = (state == S_MIX);
    cmd.fin_en  = (state == S_FINISH);
  end

endmodule

@@ hw/rtl/psbf_datapath.sv @@
module psbf_datapath #(
  parameter int MAX_WIDTH  = psbf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = psbf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  psbf_pkg::ctrl_cmd_t         cmd,
  input  psbf_pkg::cfg_t              cfg,
  input  logic [7:0]                  pixel_x,
  input  logic [7:0]                  pixel_y,
  input  logic [psbf_pkg::CH_W-1:0]   in_red,
  input  logic [psbf_pkg::CH_W-1:0]   in_green,
  input  logic [psbf_pkg::CH_W-1:0]   in_blue,
  input  logic [psbf_pkg::CH_W-1:0]   in_alpha,
  output logic                        done,
  output logic [psbf_pkg::CH_W-1:0]   out_red,
  output logic [psbf_pkg::CH_W-1:0]   out_green,
  output logic [psbf_pkg::CH_W-1:0]   out_blue,
  output logic [psbf_pkg::CH_W-1:0]   out_alpha
);

  localparam int CH_W   = psbf_pkg::CH_W;
  localparam int PIX_W  = psbf_pkg::PIX_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XB     = $clog2(MAX_WIDTH);
  localparam int YB     = $clog2(MAX_HEIGHT);
  localparam int WEW    = $clog2(MAX_WIDTH + 1);
  localparam int HEW    = $clog2(MAX_HEIGHT + 1);
  localparam int EW     = (WEW > HEW) ? WEW : HEW;
  localparam int SXW    = (EW + 1 > 10) ? EW + 1 : 10;
  localparam int PR_W   = CH_W + 16;
  localparam int V2W    = 19;
  localparam int FPW    = 15 + V2W;
  localparam int V3W    = 22;
  localparam logic [CH_W-1:0] ONE = CH_W'(psbf_pkg::ONE_Q12);

  function automatic logic [CH_W-1:0] sat_ch(input logic [CH_W-1:0] v);
    sat_ch = (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [V3W-1:0] v);
    if (v < 0) begin
      clamp_ch = '0;
    end else if (v > V3W'(psbf_pkg::ONE_Q12)) begin
      clamp_ch = ONE;
    end else begin
      clamp_ch = CH_W'(v);
    end
  endfunction

  logic [PIX_W-1:0] mem [DEPTH];

  logic [7:0]             x_q, y_q;
  logic [CH_W-1:0]        ld_q [4];
  logic [ADDR_W-1:0]      src_addr_q;
  logic [PIX_W-1:0]       src_q;
  logic [PR_W-1:0]        pr_q [3];
  logic [14:0]            wb_q;
  logic signed [V2W-1:0]  v2_q [3];
  logic signed [FPW-1:0]  fp_q [3];

  logic [WEW-1:0]         w_eff;
  logic [HEW-1:0]         h_eff;
  logic signed [SXW-1:0]  sx_full, sy_full;
  logic [XB-1:0]          sx;
  logic [YB-1:0]          sy;
  logic [ADDR_W-1:0]      dst_addr;
  logic                   in_store;
  logic signed [V2W-1:0]  v2 [3];
  logic signed [V3W-1:0]  v3 [3];
  logic [CH_W-1:0]        res [3];
  logic                   flash_on;

  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WEW'(1);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = HEW'(1);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(cfg.frame_height);
    end

    sx_full = $signed(SXW'(x_q)) + SXW'(cfg.shake_dx);
    sy_full = $signed(SXW'(y_q)) + SXW'(cfg.shake_dy);

    if (sx_full < 0) begin
      sx = '0;
    end else if (sx_full >= $signed(SXW'(w_eff))) begin
      sx = XB'(w_eff - WEW'(1));
    end else begin
      sx = XB'(sx_full);
    end
    if (sy_full < 0) begin
      sy = '0;
    end else if (sy_full >= $signed(SXW'(h_eff))) begin
      sy = YB'(h_eff - HEW'(1));
    end else begin
      sy = YB'(sy_full);
    end
  end

  assign in_store = (32'(x_q) < MAX_WIDTH) && (32'(y_q) < MAX_HEIGHT);
  assign dst_addr = ADDR_W'(32'(y_q) * MAX_WIDTH + 32'(x_q));
  assign flash_on = (32'(cfg.flash_level) >= psbf_pkg::FLASH_MIN);

  always_comb begin
    v2[0] = $signed(V2W'(pr_q[0][PR_W-1:12])) + $signed(V2W'(cfg.warm_shift[15:1]));
    v2[1] = $signed(V2W'(pr_q[1][PR_W-1:12]));
    v2[2] = $signed(V2W'(pr_q[2][PR_W-1:12])) - $signed(V2W'(wb_q));
    for (int i = 0; i < 3; i++) begin
      v3[i] = flash_on ? V3W'(v2_q[i]) + V3W'(fp_q[i] >>> 12) : V3W'(v2_q[i]);
      res[i] = clamp_ch(v3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      x_q   <= pixel_x;
      y_q   <= pixel_y;
      ld_q[0] <= sat_ch(in_red);
      ld_q[1] <= sat_ch(in_green);
      ld_q[2] <= sat_ch(in_blue);
      ld_q[3] <= sat_ch(in_alpha);
    end
    if (cmd.addr_en) begin
      src_addr_q <= ADDR_W'(32'(sy) * MAX_WIDTH + 32'(sx));
    end
    if (cmd.mul_en) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= PR_W'(src_q[i*CH_W +: CH_W]) * PR_W'(cfg.brightness_gain);
      end
      wb_q <= 15'((27'(cfg.warm_shift) * 27'(psbf_pkg::THREE_TENTHS_Q12)) >> 12);
    end
    if (cmd.mix_en) begin
      for (int i = 0; i < 3; i++) begin
        v2_q[i] <= v2[i];
        fp_q[i] <= $signed(FPW'({1'b0, cfg.flash_level}))
                   * FPW'($signed(V2W'(psbf_pkg::ONE_Q12)) - v2[i]);
      end
    end
    if (cmd.fin_en) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      out_alpha <= src_q[3*CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      src_q <= mem[src_addr_q];
    end
    if (cmd.load_wr && in_store) begin
      mem[dst_addr] <= {ld_q[3], ld_q[2], ld_q[1], ld_q[0]};
    end else if (cmd.fin_en && in_store) begin
      mem[dst_addr] <= {src_q[3*CH_W +: CH_W], res[2], res[1], res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin_en;
    end
  end

endmodule

@@ hw/rtl/pixel_shake_brightness_flash_fx_core.sv @@
// For a load command, busy is high for one cycle after it is accepted and the pixel is
// written. For a process command, busy stays high while the source address is formed,
// the pixel memory is read, and two registered multiply stages apply gain, warm shift
// and flash; the result appears on the result ports with done high for exactly one
// cycle, and start is taken again in that same cycle. The receiver cannot stall, so
// every done beat must be captured when it is shown.
module pixel_shake_brightness_flash_fx_core #(
  parameter int MAX_WIDTH  = psbf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = psbf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [7:0]                  pixel_x,
  input  logic [7:0]                  pixel_y,
  input  logic [psbf_pkg::CH_W-1:0]   in_red,
  input  logic [psbf_pkg::CH_W-1:0]   in_green,
  input  logic [psbf_pkg::CH_W-1:0]   in_blue,
  input  logic [psbf_pkg::CH_W-1:0]   in_alpha,
  output logic                        done,
  output logic [psbf_pkg::CH_W-1:0]   out_red,
  output logic [psbf_pkg::CH_W-1:0]   out_green,
  output logic [psbf_pkg::CH_W-1:0]   out_blue,
  output logic [psbf_pkg::CH_W-1:0]   out_alpha,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psbf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  psbf_pkg::cfg_t      cfg;
  psbf_pkg::ctrl_cmd_t cmd;

  psbf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psbf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .cmd   (cmd)
  );

  psbf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule

@@ hw/rtl/psbf_checker.sv @@
module psbf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [psbf_pkg::CH_W-1:0]   out_red,
  input logic [psbf_pkg::CH_W-1:0]   out_green,
  input logic [psbf_pkg::CH_W-1:0]   out_blue,
  input logic                        pready
);

  localparam logic [psbf_pkg::CH_W-1:0] ONE = psbf_pkg::CH_W'(psbf_pkg::ONE_Q12);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done beat lasted more than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done beat without a command in flight");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_red <= ONE) && (out_green <= ONE) && (out_blue <= ONE))
    else $error("result channel above full scale");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind pixel_shake_brightness_flash_fx_core psbf_checker u_psbf_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .pready    (pready)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import psbf_pkg::*;

  localparam int STORE_W = MAX_WIDTH_DEFAULT;
  localparam int STORE_H = MAX_HEIGHT_DEFAULT;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    func_t           func;
    logic [7:0]      x;
    logic [7:0]      y;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_cmd_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = 1'b0;
  logic [7:0] pixel_x = '0;
  logic [7:0] pixel_y = '0;
  logic [CH_W-1:0] in_red = '0;
  logic [CH_W-1:0] in_green = '0;
  logic [CH_W-1:0] in_blue = '0;
  logic [CH_W-1:0] in_alpha = '0;
  logic done;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cfg_t  fx_cfg;
  rgba_t frame_store [STORE_W*STORE_H];
  bit    stored_flag [STORE_W*STORE_H];
  rgba_t expected_pixels [$];

  int  fail_count = 0;
  int  cmds_sent = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  bit  idle_on = 1'b1;

  pixel_shake_brightness_flash_fx_core i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [CH_W-1:0] sat_q12(logic [CH_W-1:0] c);
    return (c > ONE_Q12) ? CH_W'(ONE_Q12) : c;
  endfunction

  function automatic logic [CH_W-1:0] clamp_q12(longint v);
    if (v < 0) return '0;
    if (v > ONE_Q12) return CH_W'(ONE_Q12);
    return CH_W'(v);
  endfunction

  function automatic longint flash_mix(longint v);
    longint level;
    level = fx_cfg.flash_level;
    if (level < FLASH_MIN) return v;
    return v + ((level * (ONE_Q12 - v)) >>> 12);
  endfunction

  function automatic int eff_dim(logic [8:0] v, int limit);
    if (v < 1) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int clamp_coord(int c, int size);
    if (c < 0) return 0;
    if (c >= size) return size - 1;
    return c;
  endfunction

  function automatic int src_index(logic [7:0] x, logic [7:0] y);
    int sx, sy;
    sx = clamp_coord(int'(x) + int'($signed(fx_cfg.shake_dx)),
                     eff_dim(fx_cfg.frame_width, STORE_W));
    sy = clamp_coord(int'(y) + int'($signed(fx_cfg.shake_dy)),
                     eff_dim(fx_cfg.frame_height, STORE_H));
    return sy * STORE_W + sx;
  endfunction

  function automatic void apply_pixel_cmd(pixel_cmd_t c);
    int dst;
    rgba_t src, res;
    longint r, g, b, gain_v, warm_v;
    dst = int'(c.y) * STORE_W + int'(c.x);
    if (c.func == FUNC_LOAD) begin
      if (c.x < STORE_W && c.y < STORE_H) begin
        res.red = sat_q12(c.red);
        res.green = sat_q12(c.green);
        res.blue = sat_q12(c.blue);
        res.alpha = sat_q12(c.alpha);
        frame_store[dst] = res;
        stored_flag[dst] = 1'b1;
      end
      return;
    end
    src = frame_store[src_index(c.x, c.y)];
    gain_v = fx_cfg.brightness_gain;
    warm_v = fx_cfg.warm_shift;
    r = (longint'(src.red) * gain_v) >>> 12;
    g = (longint'(src.green) * gain_v) >>> 12;
    b = (longint'(src.blue) * gain_v) >>> 12;
    r = r + (warm_v >>> 1);
    b = b - ((warm_v * THREE_TENTHS_Q12) >>> 12);
    res.red = clamp_q12(flash_mix(r));
    res.green = clamp_q12(flash_mix(g));
    res.blue = clamp_q12(flash_mix(b));
    res.alpha = src.alpha;
    expected_pixels.push_back(res);
    if (c.x < STORE_W && c.y < STORE_H) begin
      frame_store[dst] = res;
      stored_flag[dst] = 1'b1;
    end
  endfunction

  function automatic pixel_cmd_t pixel_cmd(func_t f, logic [7:0] x, logic [7:0] y,
                                           logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                           logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    pixel_cmd_t c;
    c.func = f;
    c.x = x;
    c.y = y;
    c.red = r;
    c.green = g;
    c.blue = b;
    c.alpha = a;
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_ch();
    if ($urandom_range(0, 7) == 0) return CH_W'($urandom_range(0, 8191));
    return CH_W'($urandom_range(0, ONE_Q12));
  endfunction

  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, span));
  endfunction

  task automatic send_cmd(pixel_cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= c.func;
    pixel_x <= c.x;
    pixel_y <= c.y;
    in_red <= c.red;
    in_green <= c.green;
    in_blue <= c.blue;
    in_alpha <= c.alpha;
    do @(posedge clk); while (busy);
    apply_pixel_cmd(c);
    cmds_sent++;
  endtask

  // The source pixel is loaded first whenever it has never been written.
  task automatic process_pixel(logic [7:0] x, logic [7:0] y);
    int s;
    s = src_index(x, y);
    if (!stored_flag[s]) begin
      send_cmd(pixel_cmd(FUNC_LOAD, 8'(s % STORE_W), 8'(s / STORE_W),
                         rand_ch(), rand_ch(), rand_ch(), rand_ch()));
    end
    send_cmd(pixel_cmd(FUNC_PROCESS, x, y, rand_ch(), rand_ch(), rand_ch(), rand_ch()));
  endtask

  task automatic drain();
    start <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never came out", expected_pixels.size());
      fail_count++;
      expected_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  fx_cfg.frame_width = data[8:0];
      REG_FRAME_HEIGHT: fx_cfg.frame_height = data[8:0];
      REG_SHAKE_DX:     fx_cfg.shake_dx = data[8:0];
      REG_SHAKE_DY:     fx_cfg.shake_dy = data[8:0];
      REG_GAIN:         fx_cfg.brightness_gain = data[15:0];
      REG_WARM_SHIFT:   fx_cfg.warm_shift = data[15:0];
      REG_FLASH_LEVEL:  fx_cfg.flash_level = data[13:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int w, int h, int dx, int dy);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_SHAKE_DX, dx);
    write_reg(REG_SHAKE_DY, dy);
    settings_used++;
  endtask

  task automatic set_effects(int gain, int warm, int flash);
    drain();
    write_reg(REG_GAIN, gain);
    write_reg(REG_WARM_SHIFT, warm);
    write_reg(REG_FLASH_LEVEL, flash);
    settings_used++;
  endtask

  task automatic test_load_and_identity();
    send_cmd(pixel_cmd(FUNC_LOAD, 8'd0, 8'd0, '0, '0, '0, '0));
    send_cmd(pixel_cmd(FUNC_LOAD, 8'd255, 8'd255, '1, '1, '1, '1));
    send_cmd(pixel_cmd(FUNC_LOAD, 8'd1, 8'd0, 13'd4096, 13'd4096, 13'd4096, 13'd4096));
    send_cmd(pixel_cmd(FUNC_LOAD, 8'd0, 8'd1, 13'h1555, 13'h0aaa, 13'd4095, 13'd4097));
    process_pixel(8'd0, 8'd0);
    process_pixel(8'd255, 8'd255);
    process_pixel(8'd1, 8'd0);
    process_pixel(8'd0, 8'd1);
  endtask

  task automatic test_effect_extremes();
    set_effects(65535, 65535, 16383);
    process_pixel(8'd1, 8'd0);
    set_effects(0, 4096, FLASH_MIN - 1);
    process_pixel(8'd0, 8'd1);
    set_effects(GAIN_RST, 0, FLASH_MIN);
    process_pixel(8'd0, 8'd0);
  endtask

  task automatic test_shake_and_frame();
    set_geometry(0, 511, -256, 255);
    process_pixel(8'd255, 8'd0);
    set_geometry(511, 0, 255, -256);
    process_pixel(8'd0, 8'd255);
    set_geometry(16, 16, 3, -2);
    process_pixel(8'd200, 8'd200);
  endtask

  task automatic test_spare_register();
    drain();
    write_reg(REG_SPARE, 32'hffff_ffff);
    process_pixel(8'd1, 8'd0);
  endtask

  task automatic random_config();
    int w, h, dx, dy, gain, warm, flash;
    int pick [7];
    foreach (pick[i]) pick[i] = $urandom_range(0, 9);
    w = (pick[0] == 0) ? 0 : (pick[0] == 1) ? 256 : (pick[0] == 2) ? $urandom_range(257, 511) :
        (pick[0] == 3) ? 1 : $urandom_range(2, 24);
    h = (pick[1] == 0) ? 0 : (pick[1] == 1) ? 256 : (pick[1] == 2) ? $urandom_range(257, 511) :
        (pick[1] == 3) ? 1 : $urandom_range(2, 24);
    dx = (pick[2] == 0) ? -256 : (pick[2] == 1) ? 255 : (pick[2] == 2) ?
         $urandom_range(0, 511) - 256 : $urandom_range(0, 8) - 4;
    dy = (pick[3] == 0) ? -256 : (pick[3] == 1) ? 255 : (pick[3] == 2) ?
         $urandom_range(0, 511) - 256 : $urandom_range(0, 8) - 4;
    gain = (pick[4] == 0) ? 0 : (pick[4] == 1) ? 65535 : (pick[4] == 2) ?
           $urandom_range(0, 65535) : $urandom_range(2048, 8192);
    warm = (pick[5] == 0) ? 65535 : (pick[5] == 1) ? $urandom_range(0, 65535) :
           (pick[5] < 4) ? $urandom_range(0, 4096) : 0;
    flash = (pick[6] == 0) ? 16383 : (pick[6] == 1) ? FLASH_MIN - 1 :
            (pick[6] == 2) ? FLASH_MIN : (pick[6] == 3) ? $urandom_range(0, 16383) :
            (pick[6] < 6) ? $urandom_range(0, 4096) : 0;
    set_geometry(w, h, dx, dy);
    set_effects(gain, warm, flash);
  endtask

  task automatic run_random_phase(int count);
    int span_x, span_y;
    int stop;
    logic [7:0] x, y;
    span_x = eff_dim(fx_cfg.frame_width, STORE_W) + 2;
    span_y = eff_dim(fx_cfg.frame_height, STORE_H) + 2;
    if (span_x > 255) span_x = 255;
    if (span_y > 255) span_y = 255;
    stop = cmds_sent + count;
    while (cmds_sent < stop) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      x = pick_coord(span_x);
      y = pick_coord(span_y);
      if ($urandom_range(0, 9) < 4) begin
        send_cmd(pixel_cmd(FUNC_LOAD, x, y, rand_ch(), rand_ch(), rand_ch(), rand_ch()));
      end else begin
        process_pixel(x, y);
      end
    end
  endtask

  task automatic test_random_effects();
    for (int phase = 0; phase < 12; phase++) begin
      random_config();
      run_random_phase(150);
    end
  endtask

  always @(posedge clk) begin : check_results
    rgba_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("Result beat with no pixel expected");
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_red !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_red);
          fail_count++;
        end
        if (out_green !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_green);
          fail_count++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_blue);
          fail_count++;
        end
        if (out_alpha !== want.alpha) begin
          $error("out_alpha: expected %0d, actual %0d", want.alpha, out_alpha);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fx_cfg.frame_width = FRAME_WIDTH_RST;
    fx_cfg.frame_height = FRAME_HEIGHT_RST;
    fx_cfg.shake_dx = '0;
    fx_cfg.shake_dy = '0;
    fx_cfg.brightness_gain = GAIN_RST;
    fx_cfg.warm_shift = '0;
    fx_cfg.flash_level = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_and_identity();
    test_effect_extremes();
    test_shake_and_frame();
    test_spare_register();
    test_random_effects();
    drain();
    $display("Sent %0d load and process commands and checked %0d processed pixels",
             cmds_sent, results_checked);
    $display("across %0d register settings, frame and effect extremes included.",
             settings_used);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/psbf_pkg.sv
hw/rtl/psbf_regs.sv
hw/rtl/psbf_ctrl.sv
hw/rtl/psbf_datapath.sv
hw/rtl/pixel_shake_brightness_flash_fx_core.sv
hw/rtl/psbf_checker.sv
tb/tb_top.sv
